// ===== hw/rtl/csb_pkg.sv =====
// Shared constants and types for the clipped colormap sprite blitter.
// Depends on nothing; the top level imports it.
package csb_pkg;

    localparam int NUM_MAPS    = 16;
    localparam int MAX_SURFACE = 1024;

    // Field widths of the input and result items.
    localparam int SEL_W   = 4;
    localparam int CODE_W  = 8;
    localparam int PIX_W   = 8;
    localparam int ORG_W   = 12;
    localparam int OFS_W   = 10;
    localparam int ADDR_W  = 20;

    // Configuration register widths.
    localparam int VIEW_POS_W = 10;
    localparam int VIEW_DIM_W = 11;
    localparam int SURF_REG_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Colormap store addressing: map number above the entry index.
    localparam int MAP_SEL_RAW = (NUM_MAPS <= 2) ? 1 : $clog2(NUM_MAPS);
    localparam int MAP_SEL_W   = (MAP_SEL_RAW < SEL_W) ? MAP_SEL_RAW : SEL_W;
    localparam int MAP_AW      = MAP_SEL_W + CODE_W;
    localparam int MAP_DEPTH   = 2 ** MAP_AW;

    // Coordinate arithmetic widths.
    localparam int SURF_W     = $clog2(MAX_SURFACE + 1);
    localparam int SURF_CMP_W = (SURF_W > SURF_REG_W) ? SURF_W : SURF_REG_W;
    localparam int COORD_W    = $clog2(MAX_SURFACE);
    localparam int REL_W      = ORG_W + 1;
    localparam int POS_W      = REL_W + 1;
    localparam int PROD_W     = COORD_W + SURF_W + 1;

    localparam logic [PIX_W-1:0] TRANSPARENT_INDEX = 8'hFF;

    localparam logic [VIEW_DIM_W-1:0] VIEW_WIDTH_RESET  = 11'd320;
    localparam logic [VIEW_DIM_W-1:0] VIEW_HEIGHT_RESET = 11'd200;
    localparam logic [SURF_REG_W-1:0] SURFACE_RESET     = 11'd512;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_X        = 3'd0,
        CFG_VIEW_Y        = 3'd1,
        CFG_VIEW_WIDTH    = 3'd2,
        CFG_VIEW_HEIGHT   = 3'd3,
        CFG_SURFACE_SIZE  = 3'd4,
        CFG_TARGET_BUFFER = 3'd5
    } cfg_index_t;

endpackage

// ===== hw/rtl/csb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module csb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/clipped_colormap_sprite_blitter.sv =====
// Top level of the clipped colormap sprite blitter: four-stage pixel pipeline.
// Depends on csb_pkg and on csb_ram for the colormap store.
//
// The blitter takes one item per cycle unless stalled and returns exactly one
// result item for each, in order, after the stage 1 to stage 4 registers. Its
// throughput is one item per clock unless stalled; the only shared resource is
// the colormap RAM, which is written by a load item and read by a draw item in
// the cycle that item is accepted, so a draw always sees every load accepted
// before it. A load item returns a result with write_enable low. A draw item is
// placed at the viewport origin plus its sprite origin plus its offset, clipped
// against the viewport and the surface, and mapped through the selected
// colormap; a mapped index of 255 is transparent and gives no write. The
// framebuffer address is x + y * surface_size, with surface_size saturated at
// the largest surface. The colormap store is not cleared by reset: drawing
// through an entry that was never loaded gives an undefined pixel value.
// Configuration registers may only be written while the pipeline is empty.
module clipped_colormap_sprite_blitter (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [csb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csb_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic signed [csb_pkg::ORG_W-1:0]  s_origin_x,
    input  logic signed [csb_pkg::ORG_W-1:0]  s_origin_y,
    input  logic [csb_pkg::OFS_W-1:0]         s_offset_x,
    input  logic [csb_pkg::OFS_W-1:0]         s_offset_y,
    input  logic [csb_pkg::SEL_W-1:0]         s_map_select,
    input  logic [csb_pkg::CODE_W-1:0]        s_pixel_code,
    input  logic [csb_pkg::PIX_W-1:0]         s_entry_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_write_enable,
    output logic                              m_buffer_select,
    output logic [csb_pkg::ADDR_W-1:0]        m_pixel_address,
    output logic [csb_pkg::PIX_W-1:0]         m_pixel_value
);

    import csb_pkg::*;

    // Configuration registers.
    logic [VIEW_POS_W-1:0] view_x_reg;
    logic [VIEW_POS_W-1:0] view_y_reg;
    logic [VIEW_DIM_W-1:0] view_width_reg;
    logic [VIEW_DIM_W-1:0] view_height_reg;
    logic [SURF_REG_W-1:0] surface_size_reg;
    logic                  target_buffer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_x_reg        <= '0;
            view_y_reg        <= '0;
            view_width_reg    <= VIEW_WIDTH_RESET;
            view_height_reg   <= VIEW_HEIGHT_RESET;
            surface_size_reg  <= SURFACE_RESET;
            target_buffer_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_VIEW_X:        view_x_reg        <= cfg_data[VIEW_POS_W-1:0];
                CFG_VIEW_Y:        view_y_reg        <= cfg_data[VIEW_POS_W-1:0];
                CFG_VIEW_WIDTH:    view_width_reg    <= cfg_data[VIEW_DIM_W-1:0];
                CFG_VIEW_HEIGHT:   view_height_reg   <= cfg_data[VIEW_DIM_W-1:0];
                CFG_SURFACE_SIZE:  surface_size_reg  <= cfg_data[SURF_REG_W-1:0];
                CFG_TARGET_BUFFER: target_buffer_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The effective surface side: the register saturated at the largest surface.
    logic [SURF_W-1:0] surf_side;
    always_comb begin
        if (SURF_CMP_W'(surface_size_reg) > SURF_CMP_W'(MAX_SURFACE)) begin
            surf_side = SURF_W'(MAX_SURFACE);
        end else begin
            surf_side = SURF_W'(surface_size_reg);
        end
    end

    // Pipeline flow control. Each stage may load when it is empty or when the
    // stage after it is moving, so bubbles are squeezed out and a result that
    // waits at the output does not block items further up.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en;

    assign s4_en   = !s4_valid_reg || m_ready;
    assign s3_en   = !s3_valid_reg || s4_en;
    assign s2_en   = !s2_valid_reg || s3_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s_ready = s1_en;

    logic accept;
    logic sel_in_range;
    assign accept       = s_valid && s_ready;
    assign sel_in_range = int'(s_map_select) < NUM_MAPS;

    // Stage 1: colormap access and sprite-relative position.
    logic [MAP_AW-1:0] map_addr;
    logic [PIX_W-1:0]  map_data;
    logic              map_write;

    assign map_addr  = {s_map_select[MAP_SEL_W-1:0], s_pixel_code};
    assign map_write = accept && (cmd_t'(s_cmd) == CMD_LOAD) && sel_in_range;

    csb_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAP_DEPTH)
    ) u_colormap (
        .aclk    (aclk),
        .wr_en   (map_write),
        .wr_addr (map_addr),
        .wr_data (s_entry_value),
        .rd_en   (accept),
        .rd_addr (map_addr),
        .rd_data (map_data)
    );

    logic                    s1_draw_reg;
    logic signed [REL_W-1:0] s1_rel_x_reg;
    logic signed [REL_W-1:0] s1_rel_y_reg;
    logic signed [REL_W-1:0] rel_x_next;
    logic signed [REL_W-1:0] rel_y_next;

    assign rel_x_next = REL_W'(s_origin_x) + $signed({{(REL_W-OFS_W){1'b0}}, s_offset_x});
    assign rel_y_next = REL_W'(s_origin_y) + $signed({{(REL_W-OFS_W){1'b0}}, s_offset_y});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_draw_reg  <= (cmd_t'(s_cmd) == CMD_DRAW) && sel_in_range;
            s1_rel_x_reg <= rel_x_next;
            s1_rel_y_reg <= rel_y_next;
        end
    end

    // Stage 2: surface position and clipping. Because the viewport origin is
    // added to both sides, the viewport test reduces to rel < width.
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] rel_x_ext;
    logic signed [POS_W-1:0] rel_y_ext;
    logic signed [POS_W-1:0] surf_ext;
    logic                    visible;
    logic                    write_next;

    assign rel_x_ext = POS_W'(s1_rel_x_reg);
    assign rel_y_ext = POS_W'(s1_rel_y_reg);
    assign surf_ext  = $signed(POS_W'(surf_side));
    assign pos_x     = $signed(POS_W'(view_x_reg)) + rel_x_ext;
    assign pos_y     = $signed(POS_W'(view_y_reg)) + rel_y_ext;

    assign visible = !s1_rel_x_reg[REL_W-1] && !s1_rel_y_reg[REL_W-1]
                  && (rel_x_ext < $signed(POS_W'(view_width_reg)))
                  && (rel_y_ext < $signed(POS_W'(view_height_reg)))
                  && (pos_x < surf_ext) && (pos_y < surf_ext);

    assign write_next = s1_draw_reg && visible && (map_data != TRANSPARENT_INDEX);

    logic               s2_write_reg;
    logic [COORD_W-1:0] s2_x_reg;
    logic [COORD_W-1:0] s2_y_reg;
    logic [PIX_W-1:0]   s2_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            s2_write_reg <= write_next;
            s2_x_reg     <= pos_x[COORD_W-1:0];
            s2_y_reg     <= pos_y[COORD_W-1:0];
            s2_value_reg <= map_data;
        end
    end

    // Stage 3: row offset, y times the surface pitch.
    logic                      s3_write_reg;
    logic [COORD_W-1:0]        s3_x_reg;
    logic [COORD_W+SURF_W-1:0] s3_row_reg;
    logic [PIX_W-1:0]          s3_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en) begin
            s3_write_reg <= s2_write_reg;
            s3_x_reg     <= s2_x_reg;
            s3_row_reg   <= (COORD_W+SURF_W)'(s2_y_reg) * (COORD_W+SURF_W)'(surf_side);
            s3_value_reg <= s2_value_reg;
        end
    end

    // Stage 4: final address and the output register. A result without a
    // write carries zero address and value.
    logic [PROD_W-1:0] addr_sum;
    assign addr_sum = PROD_W'(s3_x_reg) + PROD_W'(s3_row_reg);

    logic              s4_write_reg;
    logic              s4_buffer_reg;
    logic [ADDR_W-1:0] s4_addr_reg;
    logic [PIX_W-1:0]  s4_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_en) begin
            s4_write_reg  <= s3_write_reg;
            s4_buffer_reg <= target_buffer_reg;
            s4_addr_reg   <= s3_write_reg ? ADDR_W'(addr_sum) : '0;
            s4_value_reg  <= s3_write_reg ? s3_value_reg : '0;
        end
    end

    assign m_valid         = s4_valid_reg;
    assign m_write_enable  = s4_write_reg;
    assign m_buffer_select = s4_buffer_reg;
    assign m_pixel_address = s4_addr_reg;
    assign m_pixel_value   = s4_value_reg;

    // A written pixel is never the transparent index.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_enable |-> m_pixel_value != TRANSPARENT_INDEX)
        else $error("transparent pixel written");

    // A result without a write carries zero address and value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_pixel_address == '0 && m_pixel_value == '0)
        else $error("non-write result carries data");

    // An accepted item always occupies the first stage on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item lost at stage 1");

    // A stalled first stage keeps its item and the colormap read data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_en |=> s1_valid_reg && $stable(map_data)
                                   && $stable(s1_rel_x_reg) && $stable(s1_draw_reg))
        else $error("stage 1 changed while stalled");

    // A write flag that has just entered stage 2 always comes from a draw item
    // whose map number is in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_write_reg && $past(s2_en) |-> $past(s1_draw_reg))
        else $error("write flagged for a non-draw item");

endmodule
